/* design/emr_pkg.sv */
// Shared types, constants and saturation helpers for the metric reduction block.
`default_nettype none
package emr_pkg;

   localparam int METRIC_WIDTH    = 32;
   localparam int TRANSFORM_WIDTH = 16;
   localparam int COUNT_WIDTH     = 24;
   localparam int LOOP_WIDTH      = 10;
   localparam int QUAD_WIDTH      = 3;
   localparam int CSR_DATA_WIDTH  = 10;
   localparam int WIDE_WIDTH      = 72;
   localparam int DIV_STEPS       = METRIC_WIDTH;
   localparam int DIV_CNT_WIDTH   = $clog2(DIV_STEPS);

   localparam logic [LOOP_WIDTH-1:0] MAX_LOOPS_RESET = LOOP_WIDTH'(64);

   // register indexes
   localparam logic CSR_MAX_LOOPS      = 1'b0;
   localparam logic CSR_FULL_REDUCTION = 1'b1;

   // quadrant codes
   localparam logic [QUAD_WIDTH-1:0] QUAD_OUTSIDE = 3'd0;
   localparam logic [QUAD_WIDTH-1:0] QUAD_A_LT_POS = 3'd1;
   localparam logic [QUAD_WIDTH-1:0] QUAD_A_LT_NEG = 3'd2;
   localparam logic [QUAD_WIDTH-1:0] QUAD_A_GE_POS = 3'd3;
   localparam logic [QUAD_WIDTH-1:0] QUAD_A_GE_NEG = 3'd4;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_CONVERGE, OP_DIV_START, OP_DIV_STEP, OP_ROUND, OP_MUL_ND,
      OP_ADD_B, OP_MUL_T, OP_UPD_D, OP_UPD_T0, OP_UPD_T1, OP_FINAL
   } dp_op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_DIV, ST_ROUND, ST_MUL_ND, ST_ADD_B, ST_MUL_T,
      ST_UPD_D, ST_UPD_T0, ST_UPD_T1, ST_FINAL
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic in_domain;
      logic b_zero;
      logic d_zero;
      logic n_zero;
   } dp_status_type;

   // clamp a wide signed value to the metric width
   function automatic logic signed [METRIC_WIDTH-1:0] sat_metric(
      input logic signed [WIDE_WIDTH-1:0] x);
      logic signed [WIDE_WIDTH-1:0] hi;
      logic signed [WIDE_WIDTH-1:0] lo;
      hi = (WIDE_WIDTH'(1) <<< (METRIC_WIDTH-1)) - WIDE_WIDTH'(1);
      lo = -hi - WIDE_WIDTH'(1);
      if (x > hi) return hi[METRIC_WIDTH-1:0];
      else if (x < lo) return lo[METRIC_WIDTH-1:0];
      else return x[METRIC_WIDTH-1:0];
   endfunction

   // clamp a wide signed value to the transform width
   function automatic logic signed [TRANSFORM_WIDTH-1:0] sat_transform(
      input logic signed [WIDE_WIDTH-1:0] x);
      logic signed [WIDE_WIDTH-1:0] hi;
      logic signed [WIDE_WIDTH-1:0] lo;
      hi = (WIDE_WIDTH'(1) <<< (TRANSFORM_WIDTH-1)) - WIDE_WIDTH'(1);
      lo = -hi - WIDE_WIDTH'(1);
      if (x > hi) return hi[TRANSFORM_WIDTH-1:0];
      else if (x < lo) return lo[TRANSFORM_WIDTH-1:0];
      else return x[TRANSFORM_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

/* design/emr_datapath.sv */
// Datapath: metric and transform registers, serial divider, shared multiplier, result register.
`default_nettype none
module emr_datapath (
   input  wire                                              clock,
   input  wire emr_pkg::dp_cmd_type                         cmd,
   output emr_pkg::dp_status_type                           status,
   input  wire                                              full_reduction,
   input  wire logic signed [emr_pkg::METRIC_WIDTH-1:0]     req_metric_a,
   input  wire logic signed [emr_pkg::METRIC_WIDTH-1:0]     req_metric_b,
   input  wire logic signed [emr_pkg::METRIC_WIDTH-1:0]     req_metric_c,
   output logic signed [emr_pkg::METRIC_WIDTH-1:0]          rsp_reduced_a,
   output logic signed [emr_pkg::METRIC_WIDTH-1:0]          rsp_reduced_b,
   output logic signed [emr_pkg::METRIC_WIDTH-1:0]          rsp_reduced_c,
   output logic signed [emr_pkg::TRANSFORM_WIDTH-1:0]       rsp_transform_00,
   output logic signed [emr_pkg::TRANSFORM_WIDTH-1:0]       rsp_transform_01,
   output logic signed [emr_pkg::TRANSFORM_WIDTH-1:0]       rsp_transform_10,
   output logic signed [emr_pkg::TRANSFORM_WIDTH-1:0]       rsp_transform_11,
   output logic [emr_pkg::COUNT_WIDTH-1:0]                  rsp_shear_count,
   output logic [emr_pkg::QUAD_WIDTH-1:0]                   rsp_quadrant,
   output logic                                             rsp_converged
);
   import emr_pkg::*;

   localparam int MW = METRIC_WIDTH;
   localparam int TW = TRANSFORM_WIDTH;
   localparam int NW = MW + 2;
   localparam int YW = MW + 3;

   logic signed [MW-1:0] a_ff, b_ff, c_ff;
   logic signed [TW-1:0] t00_ff, t01_ff, t10_ff, t11_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic use_a_ff;
   logic [MW-1:0] rem_ff, quo_ff, div_ff;
   logic signed [NW-1:0] n_ff;
   logic signed [YW-1:0] t_ff;
   logic signed [WIDE_WIDTH-1:0] prod_ff;
   logic conv_ff;

   logic signed [MW-1:0] mn, d_cur;
   logic [MW:0] mag_b, mag_d;
   logic use_a_cur, in_dom;
   logic [MW:0] trial;
   logic [MW:0] qn;
   logic signed [NW-1:0] n_in;
   logic signed [YW-1:0] mul_y;
   logic signed [NW+YW-1:0] mul_p;
   logic signed [WIDE_WIDTH-1:0] prod_in;
   logic signed [WIDE_WIDTH-1:0] b_sum, t0_sum, t1_sum;
   logic signed [TW-1:0] src0, src1, dst0, dst1;
   logic [MW:0] count_room;
   logic signed [MW-1:0] fb;
   logic signed [TW-1:0] f01, f11;
   logic [QUAD_WIDTH-1:0] quad;

   // domain test and divisor choice
   always_comb begin
      use_a_cur = a_ff < c_ff;
      mn = use_a_cur ? a_ff : c_ff;
      mag_b = b_ff[MW-1] ? -{b_ff[MW-1], b_ff} : {1'b0, b_ff};
      in_dom = (mn > 0) && (mag_b <= ({1'b0, mn} >> 1));
      d_cur = use_a_ff ? a_ff : c_ff;
      mag_d = mn[MW-1] ? -{mn[MW-1], mn} : {1'b0, mn};
      status.in_domain = in_dom;
      status.b_zero = b_ff == '0;
      status.d_zero = mn == '0;
      status.n_zero = n_ff == '0;
   end

   // divider step and rounding to nearest, ties away from zero
   always_comb begin
      trial = {rem_ff, quo_ff[MW-1]} - {1'b0, div_ff};
      qn = {1'b0, quo_ff} + (({rem_ff, 1'b0} >= {1'b0, div_ff}) ? (MW+1)'(1) : '0);
      n_in = ((b_ff[MW-1]) == (d_cur[MW-1])) ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
      count_room = (MW+1)'({COUNT_WIDTH{1'b1}} - count_ff);
   end

   // transform columns: the source column feeds the destination column
   always_comb begin
      src0 = use_a_ff ? t00_ff : t01_ff;
      src1 = use_a_ff ? t10_ff : t11_ff;
      dst0 = use_a_ff ? t01_ff : t00_ff;
      dst1 = use_a_ff ? t11_ff : t10_ff;
   end

   // shared multiplier, operand chosen by the command
   always_comb begin
      case (cmd.op)
         OP_MUL_ND: mul_y = YW'(d_cur);
         OP_MUL_T:  mul_y = t_ff;
         OP_UPD_D:  mul_y = YW'(src0);
         OP_UPD_T0: mul_y = YW'(src1);
         default:   mul_y = t_ff;
      endcase
      mul_p = n_ff * mul_y;
      prod_in = WIDE_WIDTH'(mul_p);
      b_sum = WIDE_WIDTH'(b_ff) + prod_ff;
      t0_sum = WIDE_WIDTH'(dst0) + prod_ff;
      t1_sum = WIDE_WIDTH'(dst1) + prod_ff;
   end

   // quadrant and fundamental mapping
   always_comb begin
      if (!in_dom) quad = QUAD_OUTSIDE;
      else if (use_a_cur) quad = b_ff[MW-1] ? QUAD_A_LT_NEG : QUAD_A_LT_POS;
      else quad = b_ff[MW-1] ? QUAD_A_GE_NEG : QUAD_A_GE_POS;
      fb = b_ff;
      f01 = t01_ff;
      f11 = t11_ff;
      if (full_reduction && b_ff[MW-1]) begin
         fb = sat_metric(-WIDE_WIDTH'(b_ff));
         f01 = sat_transform(-WIDE_WIDTH'(t01_ff));
         f11 = sat_transform(-WIDE_WIDTH'(t11_ff));
      end
   end

   // advance the working registers per command
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            a_ff <= req_metric_a;
            b_ff <= req_metric_b;
            c_ff <= req_metric_c;
            t00_ff <= TW'(1);
            t01_ff <= '0;
            t10_ff <= '0;
            t11_ff <= TW'(1);
            count_ff <= '0;
            conv_ff <= 1'b0;
         end
         OP_CONVERGE: conv_ff <= 1'b1;
         OP_DIV_START: begin
            use_a_ff <= use_a_cur;
            rem_ff <= '0;
            quo_ff <= mag_b[MW-1:0];
            div_ff <= mag_d[MW-1:0];
         end
         OP_DIV_STEP: begin
            if (!trial[MW]) begin
               rem_ff <= trial[MW-1:0];
               quo_ff <= {quo_ff[MW-2:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[MW-2:0], quo_ff[MW-1]};
               quo_ff <= {quo_ff[MW-2:0], 1'b0};
            end
         end
         OP_ROUND: begin
            n_ff <= n_in;
            if (qn >= count_room) count_ff <= {COUNT_WIDTH{1'b1}};
            else count_ff <= count_ff + COUNT_WIDTH'(qn);
         end
         OP_MUL_ND: prod_ff <= prod_in;
         OP_ADD_B: begin
            b_ff <= sat_metric(b_sum);
            t_ff <= YW'(WIDE_WIDTH'(b_ff) + b_sum);
         end
         OP_MUL_T: prod_ff <= prod_in;
         OP_UPD_D: begin
            if (use_a_ff) c_ff <= sat_metric(WIDE_WIDTH'(c_ff) + prod_ff);
            else a_ff <= sat_metric(WIDE_WIDTH'(a_ff) + prod_ff);
            prod_ff <= prod_in;
         end
         OP_UPD_T0: begin
            if (use_a_ff) t01_ff <= sat_transform(t0_sum);
            else t00_ff <= sat_transform(t0_sum);
            prod_ff <= prod_in;
         end
         OP_UPD_T1: begin
            if (use_a_ff) t11_ff <= sat_transform(t1_sum);
            else t10_ff <= sat_transform(t1_sum);
         end
         default: begin
         end
      endcase
   end

   // load the result register
   always_ff @(posedge clock) begin
      if (cmd.op == OP_FINAL) begin
         rsp_reduced_b <= fb;
         rsp_shear_count <= count_ff;
         rsp_quadrant <= quad;
         rsp_converged <= conv_ff;
         if (full_reduction && (c_ff < a_ff)) begin
            rsp_reduced_a <= c_ff;
            rsp_reduced_c <= a_ff;
            rsp_transform_00 <= f01;
            rsp_transform_01 <= t00_ff;
            rsp_transform_10 <= f11;
            rsp_transform_11 <= t10_ff;
         end else begin
            rsp_reduced_a <= a_ff;
            rsp_reduced_c <= c_ff;
            rsp_transform_00 <= t00_ff;
            rsp_transform_01 <= f01;
            rsp_transform_10 <= t10_ff;
            rsp_transform_11 <= f11;
         end
      end
   end

endmodule
`default_nettype wire

/* design/emr_controller.sv */
// Controller: sequences check, division, shear updates and result hand-off.
`default_nettype none
module emr_controller (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire [emr_pkg::LOOP_WIDTH-1:0]        max_loops,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output emr_pkg::dp_cmd_type                  cmd,
   input  wire emr_pkg::dp_status_type          status
);
   import emr_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic [LOOP_WIDTH-1:0] iter_ff, iter_in;
   logic [DIV_CNT_WIDTH-1:0] div_cnt_ff, div_cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff <= '0;
         div_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         iter_ff <= iter_in;
         div_cnt_ff <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      iter_in = iter_ff;
      div_cnt_in = div_cnt_ff;
      out_free = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op = OP_NONE;
      req_stall = state_ff != ST_IDLE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_LOAD;
               iter_in = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((iter_ff != '0) && (iter_ff >= max_loops)) state_in = ST_FINAL;
            else if (status.in_domain) begin
               // mark convergence only on a domain hit
               cmd.op = OP_CONVERGE;
               state_in = ST_FINAL;
            end
            else if ((iter_ff >= max_loops) || status.b_zero || status.d_zero)
               state_in = ST_FINAL;
            else begin
               cmd.op = OP_DIV_START;
               div_cnt_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.op = OP_DIV_STEP;
            div_cnt_in = div_cnt_ff + DIV_CNT_WIDTH'(1);
            if (div_cnt_ff == DIV_CNT_WIDTH'(DIV_STEPS - 1)) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.op = OP_ROUND;
            state_in = ST_MUL_ND;
         end
         ST_MUL_ND: begin
            if (status.n_zero) state_in = ST_FINAL;
            else begin
               cmd.op = OP_MUL_ND;
               state_in = ST_ADD_B;
            end
         end
         ST_ADD_B: begin
            cmd.op = OP_ADD_B;
            state_in = ST_MUL_T;
         end
         ST_MUL_T: begin
            cmd.op = OP_MUL_T;
            state_in = ST_UPD_D;
         end
         ST_UPD_D: begin
            cmd.op = OP_UPD_D;
            state_in = ST_UPD_T0;
         end
         ST_UPD_T0: begin
            cmd.op = OP_UPD_T0;
            state_in = ST_UPD_T1;
         end
         ST_UPD_T1: begin
            cmd.op = OP_UPD_T1;
            iter_in = iter_ff + LOOP_WIDTH'(1);
            state_in = ST_CHECK;
         end
         ST_FINAL: begin
            if (out_free) begin
               cmd.op = OP_FINAL;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_CHECK))
      else $error("transaction accepted outside idle");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");
   a_iter_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (iter_ff <= max_loops))
      else $error("pass count beyond cap");
`endif

endmodule
`default_nettype wire

/* design/elastic_metric_reduction_top.sv */
// Top level: configuration registers, controller and datapath.
// Each full shear pass runs the check, the serial divider, rounding and the update states
// (multiply, add, multiply, metric and transform updates); a zero step ends the pass after rounding.
// Throughput: one transaction at a time; the next is taken the cycle after the result is
// loaded into the output register, and loading waits while an earlier result is stalled.
// Reset is synchronous, active high: clears control state, max_loops 64, full_reduction 1.
`default_nettype none
module elastic_metric_reduction_top (
   input  wire                                              clock,
   input  wire                                              reset,
   input  wire                                              csr_write_enable,
   input  wire                                              csr_index,
   input  wire [emr_pkg::CSR_DATA_WIDTH-1:0]                csr_write_data,
   input  wire                                              req_valid,
   output logic                                             req_stall,
   input  wire logic signed [emr_pkg::METRIC_WIDTH-1:0]     req_metric_a,
   input  wire logic signed [emr_pkg::METRIC_WIDTH-1:0]     req_metric_b,
   input  wire logic signed [emr_pkg::METRIC_WIDTH-1:0]     req_metric_c,
   output logic                                             rsp_valid,
   input  wire                                              rsp_stall,
   output logic signed [emr_pkg::METRIC_WIDTH-1:0]          rsp_reduced_a,
   output logic signed [emr_pkg::METRIC_WIDTH-1:0]          rsp_reduced_b,
   output logic signed [emr_pkg::METRIC_WIDTH-1:0]          rsp_reduced_c,
   output logic signed [emr_pkg::TRANSFORM_WIDTH-1:0]       rsp_transform_00,
   output logic signed [emr_pkg::TRANSFORM_WIDTH-1:0]       rsp_transform_01,
   output logic signed [emr_pkg::TRANSFORM_WIDTH-1:0]       rsp_transform_10,
   output logic signed [emr_pkg::TRANSFORM_WIDTH-1:0]       rsp_transform_11,
   output logic [emr_pkg::COUNT_WIDTH-1:0]                  rsp_shear_count,
   output logic [emr_pkg::QUAD_WIDTH-1:0]                   rsp_quadrant,
   output logic                                             rsp_converged
);
   import emr_pkg::*;

   logic [LOOP_WIDTH-1:0] max_loops_ff;
   logic full_reduction_ff;
   dp_cmd_type cmd;
   dp_status_type status;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_loops_ff <= MAX_LOOPS_RESET;
         full_reduction_ff <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_LOOPS:      max_loops_ff <= csr_write_data[LOOP_WIDTH-1:0];
            CSR_FULL_REDUCTION: full_reduction_ff <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   emr_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .max_loops (max_loops_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   emr_datapath u_dp (
      .clock            (clock),
      .cmd              (cmd),
      .status           (status),
      .full_reduction   (full_reduction_ff),
      .req_metric_a     (req_metric_a),
      .req_metric_b     (req_metric_b),
      .req_metric_c     (req_metric_c),
      .rsp_reduced_a    (rsp_reduced_a),
      .rsp_reduced_b    (rsp_reduced_b),
      .rsp_reduced_c    (rsp_reduced_c),
      .rsp_transform_00 (rsp_transform_00),
      .rsp_transform_01 (rsp_transform_01),
      .rsp_transform_10 (rsp_transform_10),
      .rsp_transform_11 (rsp_transform_11),
      .rsp_shear_count  (rsp_shear_count),
      .rsp_quadrant     (rsp_quadrant),
      .rsp_converged    (rsp_converged)
   );

endmodule
`default_nettype wire

/* bench/tb_elastic_metric_reduction_top.sv */
// Self-checking bench for the metric reduction block: random and directed metrics.
`default_nettype none
module tb_elastic_metric_reduction_top;
   timeunit 1ns;
   timeprecision 1ps;
   import emr_pkg::*;

   typedef struct packed {
      logic signed [METRIC_WIDTH-1:0] a;
      logic signed [METRIC_WIDTH-1:0] b;
      logic signed [METRIC_WIDTH-1:0] c;
   } metric_type;

   typedef struct packed {
      logic signed [METRIC_WIDTH-1:0]    a;
      logic signed [METRIC_WIDTH-1:0]    b;
      logic signed [METRIC_WIDTH-1:0]    c;
      logic signed [TRANSFORM_WIDTH-1:0] t00;
      logic signed [TRANSFORM_WIDTH-1:0] t01;
      logic signed [TRANSFORM_WIDTH-1:0] t10;
      logic signed [TRANSFORM_WIDTH-1:0] t11;
      logic [COUNT_WIDTH-1:0]            count;
      logic [QUAD_WIDTH-1:0]             quad;
      logic                              conv;
   } reduced_type;

   localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic csr_index = 1'b0;
   logic [CSR_DATA_WIDTH-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [METRIC_WIDTH-1:0] req_metric_a = '0, req_metric_b = '0, req_metric_c = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   wire reduced_type actual;

   elastic_metric_reduction_top dut (
      .clock, .reset, .csr_write_enable, .csr_index, .csr_write_data,
      .req_valid, .req_stall, .req_metric_a, .req_metric_b, .req_metric_c,
      .rsp_valid, .rsp_stall,
      .rsp_reduced_a(actual.a), .rsp_reduced_b(actual.b), .rsp_reduced_c(actual.c),
      .rsp_transform_00(actual.t00), .rsp_transform_01(actual.t01),
      .rsp_transform_10(actual.t10), .rsp_transform_11(actual.t11),
      .rsp_shear_count(actual.count), .rsp_quadrant(actual.quad),
      .rsp_converged(actual.conv));

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor copy of the registers
   logic [LOOP_WIDTH-1:0] loop_cap = MAX_LOOPS_RESET;
   logic                  fold_on = 1'b1;

   metric_type  pending_metrics[$];
   reduced_type expected_reductions[$];
   int          mismatches = 0;
   bit          pause_sender = 1'b0;
   bit          hold_receiver = 1'b0;

   function automatic longint sat_add(longint x, longint y);
      if (y > 0 && x > S64_MAX - y) return S64_MAX;
      if (y < 0 && x < S64_MIN - y) return S64_MIN;
      return x + y;
   endfunction

   function automatic longint sat_mul(longint x, longint y);
      logic signed [127:0] p;
      p = 128'(x) * 128'(y);
      if (p > 128'(S64_MAX)) return S64_MAX;
      if (p < 128'(S64_MIN)) return S64_MIN;
      return longint'(p);
   endfunction

   function automatic longint clamp_to(longint x, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      return x > hi ? hi : (x < lo ? lo : x);
   endfunction

   function automatic longint unsigned magnitude(longint x);
      return x < 0 ? 64'd0 - longint'(x) : longint'(x);
   endfunction

   function automatic bit elastic(longint a, longint b, longint c);
      longint mn;
      mn = a < c ? a : c;
      if (mn <= 0) return 1'b0;
      return magnitude(b) <= longint'(mn) / 2;
   endfunction

   // run the shear loop and the optional fundamental mapping
   function automatic reduced_type reduce_metric(metric_type m);
      reduced_type r;
      longint a, b, c, t00, t01, t10, t11, d, n, t, tmp;
      longint unsigned ub, ud, qn, rem, count, cmax;
      bit conv, use_a;
      int iter;
      a = longint'(m.a); b = longint'(m.b); c = longint'(m.c);
      t00 = 1; t01 = 0; t10 = 0; t11 = 1;
      count = 0; cmax = (64'd1 << COUNT_WIDTH) - 1;
      conv = 1'b0;
      for (iter = 0; ; iter++) begin
         if (iter != 0 && iter >= loop_cap) break;
         if (elastic(a, b, c)) begin
            conv = 1'b1;
            break;
         end
         if (iter >= loop_cap || b == 0) break;
         use_a = a < c;
         d = use_a ? a : c;
         if (d == 0) break;
         ub = magnitude(b);
         ud = magnitude(d);
         qn = ub / ud;
         rem = ub % ud;
         if (rem >= ud - rem) qn++;
         if ((b < 0) == (d < 0)) n = -longint'(qn);
         else n = longint'(qn);
         if (n == 0) break;
         t = sat_add(sat_add(b, b), sat_mul(n, d));
         b = clamp_to(sat_add(b, sat_mul(n, d)), METRIC_WIDTH);
         if (use_a) begin
            c = clamp_to(sat_add(c, sat_mul(n, t)), METRIC_WIDTH);
            t01 = clamp_to(sat_add(t01, sat_mul(n, t00)), TRANSFORM_WIDTH);
            t11 = clamp_to(sat_add(t11, sat_mul(n, t10)), TRANSFORM_WIDTH);
         end else begin
            a = clamp_to(sat_add(a, sat_mul(n, t)), METRIC_WIDTH);
            t00 = clamp_to(sat_add(t00, sat_mul(n, t01)), TRANSFORM_WIDTH);
            t10 = clamp_to(sat_add(t10, sat_mul(n, t11)), TRANSFORM_WIDTH);
         end
         if (magnitude(n) >= cmax - count) count = cmax;
         else count += magnitude(n);
      end
      if (!elastic(a, b, c)) r.quad = QUAD_OUTSIDE;
      else if (a < c) r.quad = b >= 0 ? QUAD_A_LT_POS : QUAD_A_LT_NEG;
      else r.quad = b >= 0 ? QUAD_A_GE_POS : QUAD_A_GE_NEG;
      if (fold_on) begin
         if (b < 0) begin
            b = clamp_to(-b, METRIC_WIDTH);
            t01 = clamp_to(-t01, TRANSFORM_WIDTH);
            t11 = clamp_to(-t11, TRANSFORM_WIDTH);
         end
         if (c < a) begin
            tmp = a; a = c; c = tmp;
            tmp = t00; t00 = t01; t01 = tmp;
            tmp = t10; t10 = t11; t11 = tmp;
         end
      end
      r.a = METRIC_WIDTH'(a); r.b = METRIC_WIDTH'(b); r.c = METRIC_WIDTH'(c);
      r.t00 = TRANSFORM_WIDTH'(t00); r.t01 = TRANSFORM_WIDTH'(t01);
      r.t10 = TRANSFORM_WIDTH'(t10); r.t11 = TRANSFORM_WIDTH'(t11);
      r.count = COUNT_WIDTH'(count); r.conv = conv;
      return r;
   endfunction

   // driver: bursts of transactions with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_reductions.push_back(reduce_metric(pending_metrics.pop_front()));
         end
         if (req_valid && req_stall) begin
            // hold the stalled transaction
         end else if (pending_metrics.size() > 0 && !pause_sender && gap_left == 0) begin
            req_valid <= 1'b1;
            req_metric_a <= pending_metrics[0].a;
            req_metric_b <= pending_metrics[0].b;
            req_metric_c <= pending_metrics[0].c;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left--;
         end
      end
   end

   // receiver stall pattern and long hold-off
   always @(posedge clock) begin
      if (hold_receiver) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(0, 3) == 0) ? 1'($urandom_range(0, 1)) : 1'b0;
   end

   // monitor: compare each transaction against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reductions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", actual);
         end else if (actual !== expected_reductions[0]) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %p actual %p", expected_reductions[0], actual);
            void'(expected_reductions.pop_front());
         end else begin
            void'(expected_reductions.pop_front());
         end
      end
   end

   task automatic wait_drained();
      while (pending_metrics.size() > 0 || req_valid || expected_reductions.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, int value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= CSR_DATA_WIDTH'(value);
      if (idx == CSR_MAX_LOOPS) loop_cap = LOOP_WIDTH'(value);
      else fold_on = value[0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic signed [31:0] rnd_entry();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $signed($urandom_range(0, 20)) - 10;
         2: return $signed($urandom_range(0, 32'h0010_0000));
         3: return $signed($urandom_range(0, 32'h7FFF_FFFF));
         4: return -$signed($urandom_range(0, 32'h0100_0000));
         default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      endcase
   endfunction

   task automatic push_random(int count);
      metric_type m;
      repeat (count) begin
         m.a = rnd_entry(); m.b = rnd_entry(); m.c = rnd_entry();
         // mostly metrics with positive diagonal entries so the loop does real work
         if ($urandom_range(0, 3) != 0) begin
            m.a = $urandom_range(1, 32'h0008_0000);
            m.c = $urandom_range(1, 32'h0008_0000);
            m.b = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
         end
         pending_metrics.push_back(m);
      end
   endtask

   localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MINV = 32'sh8000_0000;

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, domain cases, zero divisors, ties
      pending_metrics.push_back('{32'sh10000, 0, 32'sh10000});
      pending_metrics.push_back('{32'sh20000, -32'sh10000, 32'sh30000});
      pending_metrics.push_back('{32'sh30000, 32'sh10000, 32'sh20000});
      pending_metrics.push_back('{32'sh30000, -32'sh10000, 32'sh20000});
      pending_metrics.push_back('{0, 32'sh10000, 32'sh10000});
      pending_metrics.push_back('{32'sh10000, 32'sh18000, 32'sh40000});
      pending_metrics.push_back('{4, 2, 100});
      pending_metrics.push_back('{4, 6, 100});
      pending_metrics.push_back('{-4, 2, 100});
      pending_metrics.push_back('{MAXV, MAXV, MAXV});
      pending_metrics.push_back('{MINV, MINV, MINV});
      pending_metrics.push_back('{1, MAXV, MAXV});
      pending_metrics.push_back('{1, MINV, MAXV});
      pending_metrics.push_back('{MAXV, MINV, 1});
      pending_metrics.push_back('{-1, -1, -1});
      pending_metrics.push_back('{0, 0, 0});
      pending_metrics.push_back('{1, 32'sh7FFF, 1});
      pending_metrics.push_back('{3, 1000, 7});
      wait_drained();
      // fill the block while the receiver holds off
      push_random(40);
      hold_receiver = 1'b1;
      repeat (8000) @(posedge clock);
      hold_receiver = 1'b0;
      wait_drained();
      // sweep register settings, extremes included
      write_reg(CSR_MAX_LOOPS, 1);
      write_reg(CSR_FULL_REDUCTION, 0);
      pending_metrics.push_back('{1, 32'sh7FFF, 1});
      push_random(300);
      wait_drained();
      write_reg(CSR_MAX_LOOPS, 1023);
      push_random(300);
      wait_drained();
      write_reg(CSR_MAX_LOOPS, 0);
      write_reg(CSR_FULL_REDUCTION, 1);
      push_random(100);
      wait_drained();
      write_reg(CSR_MAX_LOOPS, 3);
      push_random(300);
      pause_sender = 1'b1;
      while (req_valid || expected_reductions.size() > 0) @(posedge clock);
      pause_sender = 1'b0;
      wait_drained();
      write_reg(CSR_MAX_LOOPS, 64);
      push_random(550);
      wait_drained();
      if (mismatches == 0 && expected_reductions.size() == 0)
         $display("PASS elastic_metric_reduction_top");
      else
         $display("FAIL elastic_metric_reduction_top");
      $finish;
   end

   initial begin
      #300ms;
      $display("FAIL elastic_metric_reduction_top");
      $finish;
   end
endmodule
`default_nettype wire
